FILE: rtl/rha_pkg.sv
// ----------------------------------------------------------------------------
// rha_pkg: shared types and constants for the record hole allocator
// Table depths, field widths, request and status codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rha_pkg;

	// Table sizes and derived widths
	localparam int INDEX_DEPTH = 64;
	localparam int HOLE_DEPTH  = 64;
	localparam int IDX_AW      = $clog2(INDEX_DEPTH);
	localparam int HOLE_AW     = $clog2(HOLE_DEPTH);
	localparam int CNT_W       = 7;
	localparam int PTR_W       = 7;

	// Field widths
	localparam int KEY_W   = 32;
	localparam int OFF_W   = 32;
	localparam int LEN_W   = 12;
	localparam int SPACE_W = 18;
	localparam int IDX_W   = KEY_W + OFF_W + LEN_W;
	localparam int HOLE_W  = LEN_W + OFF_W;

	// Request codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_EXISTS   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Fit policy codes
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Scan pointer updates
	localparam logic [2:0] P_HOLD  = 3'd0;
	localparam logic [2:0] P_ZERO  = 3'd1;
	localparam logic [2:0] P_INC   = 3'd2;
	localparam logic [2:0] P_DEC   = 3'd3;
	localparam logic [2:0] P_LOC   = 3'd4;
	localparam logic [2:0] P_HM1   = 3'd5;
	localparam logic [2:0] P_IUSED = 3'd6;
	localparam logic [2:0] P_HUSED = 3'd7;

	// Read address relative to the pointer
	localparam logic [1:0] A_PTR = 2'd0;
	localparam logic [1:0] A_INC = 2'd1;
	localparam logic [1:0] A_DEC = 2'd2;

	// Table write kinds, always at the pointer
	localparam logic [1:0] W_NONE  = 2'd0;
	localparam logic [1:0] W_SHIFT = 2'd1;
	localparam logic [1:0] W_PUT   = 2'd2;

	typedef struct packed {
		logic       latch;
		logic [2:0] ptr_sel;
		logic [1:0] rd_sel;
		logic [1:0] idx_wr;
		logic [1:0] hole_wr;
		logic       set_found;
		logic       take_hole;
		logic       take_end;
		logic       res_fk;
		logic       st_we;
		logic [1:0] st_val;
		logic       ins_split;
		logic       ins_rec;
		logic       hole_dec;
		logic       hole_inc;
		logic       idx_dec;
		logic       idx_inc;
		logic       out_load;
	} rha_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       found;
		logic       idx_full;
		logic       hole_full;
		logic       ptr_zero;
		logic       at_iused;
		logic       at_hbound;
		logic       key_hit;
		logic       key_less;
		logic       hole_fits;
		logic       hr_end;
		logic       ir_end;
		logic       split;
		logic       ins_shift;
		logic       out_free;
	} rha_stat_t;

endpackage

FILE: rtl/rha_ram.sv
// ----------------------------------------------------------------------------
// rha_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/rha_dp.sv
// ----------------------------------------------------------------------------
// rha_dp: allocator datapath
// Index and hole tables, counters, scan pointer, request and result
// registers, and the output register.
// ----------------------------------------------------------------------------
module rha_dp import rha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rha_cmd_t          cmd,
	output rha_stat_t         st,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_data,
	input  logic [1:0]        opcode,
	input  logic [KEY_W-1:0]  key,
	input  logic [LEN_W-1:0]  record_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [OFF_W-1:0]  offset,
	output logic [LEN_W-1:0]  length,
	output logic [CNT_W-1:0]  hole_count,
	output logic [SPACE_W-1:0] hole_space,
	output logic [CNT_W-1:0]  record_count
);

	logic [1:0]         fit_q;
	logic [CNT_W-1:0]   idx_used_q, hole_used_q;
	logic [OFF_W-1:0]   end_q;
	logic [SPACE_W-1:0] total_q;
	logic [1:0]         op_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [PTR_W-1:0]   ptr_q;
	logic               found_q;
	logic [IDX_AW-1:0]  loc_q;
	logic [OFF_W-1:0]   fk_off_q;
	logic [LEN_W-1:0]   fk_len_q;
	logic [LEN_W-1:0]   hs_q, ins_size_q;
	logic [OFF_W-1:0]   ho_q, ins_off_q;
	logic [1:0]         res_st_q;
	logic [OFF_W-1:0]   res_off_q;
	logic [LEN_W-1:0]   res_len_q;

	logic [PTR_W-1:0]   ptr_inc, ptr_dec, rd_ptr;
	logic [CNT_W-1:0]   hbound;
	logic [IDX_W-1:0]   idx_rdata, idx_wdata;
	logic [HOLE_W-1:0]  hole_rdata, hole_wdata;
	logic [KEY_W-1:0]   r_key;
	logic [OFF_W-1:0]   r_ioff, r_hoff;
	logic [LEN_W-1:0]   r_ilen, r_hsize;

	assign ptr_inc = ptr_q + PTR_W'(1);
	assign ptr_dec = ptr_q - PTR_W'(1);
	assign {r_key, r_ioff, r_ilen} = idx_rdata;
	assign {r_hsize, r_hoff}       = hole_rdata;

	// Worst fit looks only at the head of the list
	assign hbound = (fit_q == FIT_WORST) ?
		((hole_used_q != '0) ? CNT_W'(1) : '0) : hole_used_q;

	// Pick the read address
	always_comb begin
		case (cmd.rd_sel)
			A_INC:   rd_ptr = ptr_inc;
			A_DEC:   rd_ptr = ptr_dec;
			default: rd_ptr = ptr_q;
		endcase
	end

	assign idx_wdata  = (cmd.idx_wr == W_PUT) ? {key_q, res_off_q, len_q} : idx_rdata;
	assign hole_wdata = (cmd.hole_wr == W_PUT) ? {ins_size_q, ins_off_q} : hole_rdata;

	rha_ram #(.WIDTH(IDX_W), .DEPTH(INDEX_DEPTH)) u_idx_ram (
		.clk   (clk),
		.we    (cmd.idx_wr != W_NONE),
		.waddr (ptr_q[IDX_AW-1:0]),
		.wdata (idx_wdata),
		.raddr (rd_ptr[IDX_AW-1:0]),
		.rdata (idx_rdata)
	);

	rha_ram #(.WIDTH(HOLE_W), .DEPTH(HOLE_DEPTH)) u_hole_ram (
		.clk   (clk),
		.we    (cmd.hole_wr != W_NONE),
		.waddr (ptr_q[HOLE_AW-1:0]),
		.wdata (hole_wdata),
		.raddr (rd_ptr[HOLE_AW-1:0]),
		.rdata (hole_rdata)
	);

	// Status back to the controller
	always_comb begin
		st.op        = op_q;
		st.found     = found_q;
		st.idx_full  = (idx_used_q == CNT_W'(INDEX_DEPTH));
		st.hole_full = (hole_used_q == CNT_W'(HOLE_DEPTH));
		st.ptr_zero  = (ptr_q == '0);
		st.at_iused  = (ptr_q == idx_used_q);
		st.at_hbound = (ptr_q == hbound);
		st.key_hit   = (r_key == key_q);
		st.key_less  = ($signed(key_q) < $signed(r_key));
		st.hole_fits = (r_hsize >= len_q);
		st.hr_end    = (ptr_inc >= hole_used_q);
		st.ir_end    = (ptr_inc >= idx_used_q);
		st.split     = (hs_q > len_q);
		case (fit_q)
			FIT_BEST:  st.ins_shift = (ins_size_q < r_hsize);
			FIT_WORST: st.ins_shift = (ins_size_q > r_hsize);
			default:   st.ins_shift = 1'b0;
		endcase
		st.out_free  = !out_valid || out_ready;
	end

	// Control registers: policy, counters, pointer, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q       <= FIT_FIRST;
			idx_used_q  <= '0;
			hole_used_q <= '0;
			end_q       <= '0;
			total_q     <= '0;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fit_q <= cfg_data;
			end
			case (cmd.ptr_sel)
				P_ZERO:  ptr_q <= '0;
				P_INC:   ptr_q <= ptr_inc;
				P_DEC:   ptr_q <= ptr_dec;
				P_LOC:   ptr_q <= PTR_W'(loc_q);
				P_HM1:   ptr_q <= hole_used_q - CNT_W'(1);
				P_IUSED: ptr_q <= idx_used_q;
				P_HUSED: ptr_q <= hole_used_q;
				default: ptr_q <= ptr_q;
			endcase
			if (cmd.latch) begin
				found_q <= 1'b0;
			end else if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.take_end) begin
				end_q <= end_q + OFF_W'(len_q);
			end
			// hole total follows removals and insertions
			if (cmd.take_hole) begin
				total_q <= total_q - SPACE_W'(r_hsize);
			end else if (cmd.hole_inc) begin
				total_q <= total_q + SPACE_W'(ins_size_q);
			end
			if (cmd.hole_dec) begin
				hole_used_q <= hole_used_q - CNT_W'(1);
			end else if (cmd.hole_inc) begin
				hole_used_q <= hole_used_q + CNT_W'(1);
			end
			if (cmd.idx_dec) begin
				idx_used_q <= idx_used_q - CNT_W'(1);
			end else if (cmd.idx_inc) begin
				idx_used_q <= idx_used_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers: request, lookup, hole and result
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= opcode;
			key_q     <= key;
			len_q     <= record_length;
			res_st_q  <= ST_DONE;
			res_off_q <= '0;
			res_len_q <= '0;
		end
		if (cmd.set_found) begin
			loc_q    <= ptr_q[IDX_AW-1:0];
			fk_off_q <= r_ioff;
			fk_len_q <= r_ilen;
		end
		if (cmd.st_we) begin
			res_st_q <= cmd.st_val;
		end
		if (cmd.res_fk) begin
			res_off_q <= fk_off_q;
			res_len_q <= fk_len_q;
		end
		if (cmd.take_hole) begin
			hs_q      <= r_hsize;
			ho_q      <= r_hoff;
			res_off_q <= r_hoff;
			res_len_q <= len_q;
		end
		if (cmd.take_end) begin
			res_off_q <= end_q;
			res_len_q <= len_q;
		end
		if (cmd.ins_split) begin
			ins_size_q <= hs_q - len_q;
			ins_off_q  <= ho_q + OFF_W'(len_q);
		end else if (cmd.ins_rec) begin
			ins_size_q <= fk_len_q;
			ins_off_q  <= fk_off_q;
		end
		if (cmd.out_load) begin
			status       <= res_st_q;
			offset       <= res_off_q;
			length       <= res_len_q;
			hole_count   <= hole_used_q;
			hole_space   <= total_q;
			record_count <= idx_used_q;
		end
	end

endmodule

FILE: rtl/rha_ctrl.sv
// ----------------------------------------------------------------------------
// rha_ctrl: allocator controller
// Sequences key lookup, hole search, list shifts and insertion one table
// entry at a time, issuing one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module rha_ctrl import rha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rha_stat_t st,
	output rha_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_FK_RD  = 5'd1;
	localparam logic [4:0] S_FK_CHK = 5'd2;
	localparam logic [4:0] S_DECIDE = 5'd3;
	localparam logic [4:0] S_HS_RD  = 5'd4;
	localparam logic [4:0] S_HS_CHK = 5'd5;
	localparam logic [4:0] S_HR_RD  = 5'd6;
	localparam logic [4:0] S_HR_WR  = 5'd7;
	localparam logic [4:0] S_HI_RD  = 5'd8;
	localparam logic [4:0] S_HI_CHK = 5'd9;
	localparam logic [4:0] S_HI_PUT = 5'd10;
	localparam logic [4:0] S_IR_RD  = 5'd11;
	localparam logic [4:0] S_IR_WR  = 5'd12;
	localparam logic [4:0] S_II_RD  = 5'd13;
	localparam logic [4:0] S_II_CHK = 5'd14;
	localparam logic [4:0] S_II_PUT = 5'd15;
	localparam logic [4:0] S_DONE   = 5'd16;

	logic [4:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and command word
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch   = 1'b1;
					cmd.ptr_sel = P_ZERO;
					state_d     = S_FK_RD;
				end
			end
			S_FK_RD: begin
				state_d = st.at_iused ? S_DECIDE : S_FK_CHK;
			end
			S_FK_CHK: begin
				if (st.key_hit) begin
					cmd.set_found = 1'b1;
					state_d       = S_DECIDE;
				end else begin
					cmd.ptr_sel = P_INC;
					state_d     = S_FK_RD;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (st.op)
					OP_ADD: begin
						if (st.found) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_EXISTS;
						end else if (st.idx_full) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_FULL;
						end else begin
							cmd.ptr_sel = P_ZERO;
							state_d     = S_HS_RD;
						end
					end
					OP_DEL: begin
						if (!st.found) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_NOTFOUND;
						end else if (st.hole_full) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_FULL;
						end else begin
							cmd.res_fk  = 1'b1;
							cmd.ins_rec = 1'b1;
							cmd.ptr_sel = P_HUSED;
							state_d     = S_HI_RD;
						end
					end
					default: begin
						if (st.found) begin
							cmd.res_fk = 1'b1;
						end else begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_NOTFOUND;
						end
					end
				endcase
			end
			// search holes in list order
			S_HS_RD: begin
				if (st.at_hbound) begin
					cmd.take_end = 1'b1;
					cmd.ptr_sel  = P_IUSED;
					state_d      = S_II_RD;
				end else begin
					state_d = S_HS_CHK;
				end
			end
			S_HS_CHK: begin
				if (st.hole_fits) begin
					cmd.take_hole = 1'b1;
					state_d       = S_HR_RD;
				end else begin
					cmd.ptr_sel = P_INC;
					state_d     = S_HS_RD;
				end
			end
			// close the gap left by the used hole
			S_HR_RD: begin
				if (st.hr_end) begin
					cmd.hole_dec = 1'b1;
					if (st.split) begin
						cmd.ins_split = 1'b1;
						cmd.ptr_sel   = P_HM1;
						state_d       = S_HI_RD;
					end else begin
						cmd.ptr_sel = P_IUSED;
						state_d     = S_II_RD;
					end
				end else begin
					cmd.rd_sel = A_INC;
					state_d    = S_HR_WR;
				end
			end
			S_HR_WR: begin
				cmd.hole_wr = W_SHIFT;
				cmd.ptr_sel = P_INC;
				state_d     = S_HR_RD;
			end
			// file a hole, shifting larger or smaller ones back
			S_HI_RD: begin
				if (st.ptr_zero) begin
					state_d = S_HI_PUT;
				end else begin
					cmd.rd_sel = A_DEC;
					state_d    = S_HI_CHK;
				end
			end
			S_HI_CHK: begin
				if (st.ins_shift) begin
					cmd.hole_wr = W_SHIFT;
					cmd.ptr_sel = P_DEC;
					state_d     = S_HI_RD;
				end else begin
					state_d = S_HI_PUT;
				end
			end
			S_HI_PUT: begin
				cmd.hole_wr  = W_PUT;
				cmd.hole_inc = 1'b1;
				if (st.op == OP_DEL) begin
					cmd.ptr_sel = P_LOC;
					state_d     = S_IR_RD;
				end else begin
					cmd.ptr_sel = P_IUSED;
					state_d     = S_II_RD;
				end
			end
			// drop the deleted index entry
			S_IR_RD: begin
				if (st.ir_end) begin
					cmd.idx_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_sel = A_INC;
					state_d    = S_IR_WR;
				end
			end
			S_IR_WR: begin
				cmd.idx_wr  = W_SHIFT;
				cmd.ptr_sel = P_INC;
				state_d     = S_IR_RD;
			end
			// insert the new key in sorted order
			S_II_RD: begin
				if (st.ptr_zero) begin
					state_d = S_II_PUT;
				end else begin
					cmd.rd_sel = A_DEC;
					state_d    = S_II_CHK;
				end
			end
			S_II_CHK: begin
				if (st.key_less) begin
					cmd.idx_wr  = W_SHIFT;
					cmd.ptr_sel = P_DEC;
					state_d     = S_II_RD;
				end else begin
					state_d = S_II_PUT;
				end
			end
			S_II_PUT: begin
				cmd.idx_wr  = W_PUT;
				cmd.idx_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/record_hole_allocator.sv
// ----------------------------------------------------------------------------
// record_hole_allocator: keyed record placement with a fit-policy hole list
// Keeps a signed-key sorted index and a hole list in two RAMs; each request
// gives one result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid/in_ready carries opcode, key, record_length.
//   Result channel out_valid/out_ready carries status, offset, length and
//   the hole and record counts after the request.
//   Configuration channel cfg_valid/cfg_ready writes fit_mode; write it
//   only while no request is in flight. cfg_ready is always high.
// Sequencing:
//   One request at a time. The controller walks the tables one entry at a
//   time (registered RAM read, then compare or shift write), through the key
//   lookup, hole search, hole shift and index shift steps.
// Reset:
//   Counts, end offset, hole total and fit_mode clear; table contents are
//   not cleared, only entries below the counts are ever read.
// Stall:
//   The result waits in the output register; the next request is taken
//   while it waits and its result holds until the register is free.
// ----------------------------------------------------------------------------
module record_hole_allocator import rha_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [KEY_W-1:0]   key,
	input  logic [LEN_W-1:0]   record_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [OFF_W-1:0]   offset,
	output logic [LEN_W-1:0]   length,
	output logic [CNT_W-1:0]   hole_count,
	output logic [SPACE_W-1:0] hole_space,
	output logic [CNT_W-1:0]   record_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data
);

	rha_cmd_t  cmd;
	rha_stat_t st;

	assign cfg_ready = 1'b1;

	rha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.key           (key),
		.record_length (record_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.offset        (offset),
		.length        (length),
		.hole_count    (hole_count),
		.hole_space    (hole_space),
		.record_count  (record_count)
	);

	// Block goes busy after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while a request is in flight");

	// Failed requests report no placement
	a_fail_no_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DONE) |-> (offset == '0) && (length == '0))
		else $error("failed request reports an offset or length");

	// Counts stay within the tables
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_count <= CNT_W'(INDEX_DEPTH))
			&& (hole_count <= CNT_W'(HOLE_DEPTH)))
		else $error("table count beyond depth");

	// Hold the result while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset)
			&& $stable(length) && $stable(hole_count) && $stable(hole_space)
			&& $stable(record_count))
		else $error("result changed while stalled");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: record hole allocator testbench
// Drives add, find and delete requests under each fit policy, predicts the
// index and hole list in a local model, and checks every result transaction
// field by field with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import rha_pkg::*;

	// Unused request and policy codes
	localparam logic [1:0] OP_SPARE  = 2'd3;
	localparam logic [1:0] FIT_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]         status;
		logic [OFF_W-1:0]   offset;
		logic [LEN_W-1:0]   length;
		logic [CNT_W-1:0]   hole_count;
		logic [SPACE_W-1:0] hole_space;
		logic [CNT_W-1:0]   record_count;
	} alloc_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic [KEY_W-1:0]   key;
	logic [LEN_W-1:0]   record_length;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [OFF_W-1:0]   offset;
	logic [LEN_W-1:0]   length;
	logic [CNT_W-1:0]   hole_count;
	logic [SPACE_W-1:0] hole_space;
	logic [CNT_W-1:0]   record_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;

	// Local copy of allocator state
	logic [KEY_W-1:0]   m_keys [INDEX_DEPTH];
	logic [OFF_W-1:0]   m_offs [INDEX_DEPTH];
	logic [LEN_W-1:0]   m_lens [INDEX_DEPTH];
	int                 m_iused;
	logic [LEN_W-1:0]   h_size [HOLE_DEPTH];
	logic [OFF_W-1:0]   h_off  [HOLE_DEPTH];
	int                 m_hused;
	logic [OFF_W-1:0]   m_end;
	logic [SPACE_W-1:0] m_htotal;
	logic [1:0]         m_fit;

	alloc_result_t      pending_results[$];
	logic [KEY_W-1:0]   live_keys[$];
	int                 error_count;
	int                 results_seen;
	bit                 calm;

	record_hole_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key(key), .record_length(record_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .offset(offset), .length(length),
		.hole_count(hole_count), .hole_space(hole_space),
		.record_count(record_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// File a hole at its policy position
	task automatic file_hole(input logic [LEN_W-1:0] sz, input logic [OFF_W-1:0] off);
		int p;
		p = m_hused;
		if (m_fit == FIT_BEST) begin
			while (p > 0 && sz < h_size[p-1]) begin
				h_size[p] = h_size[p-1]; h_off[p] = h_off[p-1]; p--;
			end
		end else if (m_fit == FIT_WORST) begin
			while (p > 0 && sz > h_size[p-1]) begin
				h_size[p] = h_size[p-1]; h_off[p] = h_off[p-1]; p--;
			end
		end
		h_size[p] = sz;
		h_off[p] = off;
		m_hused++;
		m_htotal = m_htotal + SPACE_W'(sz);
	endtask

	task automatic drop_hole(input int p);
		m_htotal = m_htotal - SPACE_W'(h_size[p]);
		while (p + 1 < m_hused) begin
			h_size[p] = h_size[p+1]; h_off[p] = h_off[p+1];
			p++;
		end
		m_hused--;
	endtask

	// Predict one request and queue its expected result
	task automatic predict_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [LEN_W-1:0] len);
		alloc_result_t r;
		int loc, pick, p;
		logic [LEN_W-1:0] hs;
		logic [OFF_W-1:0] ho;
		r = '0;
		loc = -1;
		for (int i = 0; i < m_iused; i++)
			if (loc < 0 && m_keys[i] == k) loc = i;
		if (op == OP_ADD) begin
			if (loc >= 0) r.status = ST_EXISTS;
			else if (m_iused >= INDEX_DEPTH) r.status = ST_FULL;
			else begin
				pick = -1;
				if (m_fit == FIT_WORST) begin
					if (m_hused > 0 && h_size[0] >= len) pick = 0;
				end else begin
					for (int j = 0; j < m_hused; j++)
						if (pick < 0 && h_size[j] >= len) pick = j;
				end
				if (pick >= 0) begin
					hs = h_size[pick]; ho = h_off[pick];
					r.offset = ho;
					drop_hole(pick);
					if (hs > len) file_hole(hs - len, ho + OFF_W'(len));
				end else begin
					r.offset = m_end;
					m_end = m_end + OFF_W'(len);
				end
				r.length = len;
				p = m_iused;
				while (p > 0 && $signed(k) < $signed(m_keys[p-1])) begin
					m_keys[p] = m_keys[p-1]; m_offs[p] = m_offs[p-1];
					m_lens[p] = m_lens[p-1]; p--;
				end
				m_keys[p] = k; m_offs[p] = r.offset; m_lens[p] = len;
				m_iused++;
				live_keys.push_back(k);
			end
		end else if (op == OP_DEL) begin
			if (loc < 0) r.status = ST_NOTFOUND;
			else if (m_hused >= HOLE_DEPTH) r.status = ST_FULL;
			else begin
				r.offset = m_offs[loc];
				r.length = m_lens[loc];
				file_hole(r.length, r.offset);
				for (p = loc; p + 1 < m_iused; p++) begin
					m_keys[p] = m_keys[p+1]; m_offs[p] = m_offs[p+1];
					m_lens[p] = m_lens[p+1];
				end
				m_iused--;
				foreach (live_keys[i])
					if (live_keys[i] == k) begin
						live_keys.delete(i);
						break;
					end
			end
		end else begin
			if (loc < 0) r.status = ST_NOTFOUND;
			else begin
				r.offset = m_offs[loc];
				r.length = m_lens[loc];
			end
		end
		r.hole_count = CNT_W'(m_hused);
		r.hole_space = m_htotal;
		r.record_count = CNT_W'(m_iused);
		pending_results.push_back(r);
	endtask

	// Send one request; hold until accepted, drop valid only when idling
	task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [LEN_W-1:0] len);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		record_length <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_request(op, k, len);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write fit_mode while idle
	task automatic set_fit(input logic [1:0] mode);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		m_fit = mode;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if (live_keys.size() != 0 && $urandom_range(99) < 65)
			return live_keys[$urandom_range(live_keys.size() - 1)];
		return KEY_W'($urandom_range(40)) - 20;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(9))
			0: return LEN_W'($urandom);
			1: return '1;
			default: return LEN_W'($urandom_range(64));
		endcase
	endfunction

	// Extremes of key and length, every opcode, and missing and duplicate keys
	task automatic test_directed();
		send_request(OP_FIND, 32'd5, 12'd1);
		send_request(OP_DEL, 32'd5, 12'd1);
		send_request(OP_ADD, 32'h8000_0000, 12'hFFF);
		send_request(OP_ADD, 32'h7FFF_FFFF, 12'd1);
		send_request(OP_ADD, 32'h0000_0000, 12'd0);
		send_request(OP_ADD, 32'hFFFF_FFFF, 12'd100);
		send_request(OP_ADD, 32'h7FFF_FFFF, 12'd9);
		send_request(OP_FIND, 32'h8000_0000, 12'd0);
		send_request(OP_SPARE, 32'hFFFF_FFFF, 12'd3);
		send_request(OP_DEL, 32'h0000_0000, 12'd0);
		send_request(OP_DEL, 32'h8000_0000, 12'd0);
		send_request(OP_ADD, 32'd10, 12'd4095);
		send_request(OP_ADD, 32'd11, 12'd50);
		send_request(OP_DEL, 32'hFFFF_FFFF, 12'd0);
		send_request(OP_ADD, 32'd12, 12'd100);
		send_request(OP_ADD, 32'd13, 12'd0);
		send_request(OP_FIND, 32'd11, 12'h555);
		send_request(OP_ADD, 32'h5555_5555, 12'hAAA);
		send_request(OP_ADD, 32'hAAAA_AAAA, 12'h555);
	endtask

	// Fill the index, then hit full on add and on delete
	task automatic test_full_tables();
		for (int i = 0; live_keys.size() < INDEX_DEPTH; i++)
			send_request(OP_ADD, 32'h1000 + i, LEN_W'($urandom_range(1, 8)));
		send_request(OP_ADD, 32'h0BAD_0000, 12'd1);
		while (live_keys.size() != 0 && m_hused < HOLE_DEPTH)
			send_request(OP_DEL, live_keys[$urandom_range(live_keys.size() - 1)], 12'd0);
		if (live_keys.size() != 0)
			send_request(OP_DEL, live_keys[0], 12'd0);
		for (int i = 0; i < 30; i++)
			send_request(OP_ADD, 32'h2000 + i, LEN_W'($urandom_range(1, 6)));
	endtask

	// Random mix of add, find, delete and the spare opcode; mostly live keys
	task automatic test_random(input int n);
		logic [1:0] op;
		int unsigned roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 45) op = OP_ADD;
			else if (roll < 65) op = OP_FIND;
			else if (roll < 98) op = OP_DEL;
			else op = OP_SPARE;
			if (i == n / 2) drain_results();
			calm = (i >= n / 4 && i < n / 4 + 100);
			send_request(op, (op == OP_ADD && $urandom_range(3) == 0) ?
				KEY_W'($urandom) : pick_key(), pick_len());
		end
		calm = 1'b0;
	endtask

	// Result check
	always @(posedge clk) begin
		alloc_result_t got, exp_r;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, offset, length, hole_count, hole_space, record_count};
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10) $display("unexpected result %h", got);
			end else begin
				exp_r = pending_results.pop_front();
				results_seen++;
				if (got !== exp_r) begin
					error_count++;
					if (error_count <= 10) begin
						$display("mismatch #%0d: exp st=%0d off=%h len=%0d hc=%0d hs=%0d rc=%0d",
							results_seen, exp_r.status, exp_r.offset, exp_r.length,
							exp_r.hole_count, exp_r.hole_space, exp_r.record_count);
						$display("    got st=%0d off=%h len=%0d hc=%0d hs=%0d rc=%0d",
							got.status, got.offset, got.length, got.hole_count,
							got.hole_space, got.record_count);
					end
				end
			end
		end
	end

	// Receiver stalls
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 12);

	initial begin
		in_valid = 1'b0; opcode = OP_FIND; key = '0; record_length = '0;
		cfg_valid = 1'b0; cfg_data = FIT_FIRST; out_ready = 1'b0;
		error_count = 0; results_seen = 0; calm = 1'b0;
		m_iused = 0; m_hused = 0; m_end = '0; m_htotal = '0; m_fit = FIT_FIRST;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		set_fit(FIT_BEST);
		test_random(300);
		set_fit(FIT_WORST);
		test_random(300);
		test_full_tables();
		set_fit(FIT_SPARE);
		test_random(200);
		set_fit(FIT_FIRST);
		test_random(400);
		set_fit(FIT_WORST);
		test_random(250);
		set_fit(FIT_BEST);
		test_random(250);
		drain_results();
		if (error_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#100000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
